// ===== rtl/tsp_pkg.sv =====
// Shared types and constants for the transport stream packetizer.
// Depends on nothing; every other file of the block imports it.
package tsp_pkg;

   localparam int LEN_W = 23;
   localparam int PID_W = 13;
   localparam int PCR_W = 33;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [PID_W-1:0] PID_RESET = 13'd256;

   localparam logic [7:0] SYNC_BYTE = 8'h47;
   localparam logic [7:0] PUSI_BIT = 8'h40;
   localparam logic [3:0] AFC_ADAPT = 4'h3;
   localparam logic [3:0] AFC_PAYLOAD = 4'h1;
   localparam logic [7:0] PCR_FLAG = 8'h10;
   localparam logic [6:0] PCR_RESERVED = 7'h7e;
   localparam logic [7:0] STUFF_BYTE = 8'hff;
   localparam logic [7:0] ZERO_BYTE = 8'h00;
   localparam logic [7:0] ONE_BEAT = 8'd1;

   localparam logic [7:0] FIRST_PAY_MAX = 8'd176;
   localparam logic [7:0] PAY_MAX = 8'd184;
   localparam logic [7:0] PAY_AWKWARD = 8'd183;
   localparam logic [7:0] PAY_CUT = 8'd182;
   localparam logic [7:0] ADAPT_SPAN = 8'd183;

   typedef struct packed {
      logic [7:0]       data_byte;
      logic [LEN_W-1:0] pes_length;
      logic [PCR_W-1:0] clock_reference;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] ts_byte;
      logic [7:0] repeat_count;
      logic       packet_begin;
      logic       pes_finished;
      logic       last_of_run;
   } rsp_payload_type;

   // One classified input byte, handed from the front end to the emitter.
   typedef struct packed {
      logic [7:0]       data_byte;
      logic [PCR_W-1:0] pcr;
      logic [7:0]       pay;
      logic [3:0]       cc;
      logic             first;
      logic             hdr;
      logic             finished;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [3:0] {
      SLOT_SYNC,
      SLOT_PID_HI,
      SLOT_PID_LO,
      SLOT_CC,
      SLOT_ALEN,
      SLOT_FLAGS,
      SLOT_PCR0,
      SLOT_PCR1,
      SLOT_PCR2,
      SLOT_PCR3,
      SLOT_PCR4,
      SLOT_PCR5,
      SLOT_STUFF,
      SLOT_DATA
   } slot_type;

endpackage

// ===== rtl/tsp_front.sv =====
// Front end: accepts PES bytes, tracks offset, packet fill and continuity,
// and turns each byte into a job for the emitter. Depends on tsp_pkg.
module tsp_front #(
   parameter int MAX_PES_BYTES = 4194304
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  tsp_pkg::req_payload_type req,
   output tsp_pkg::job_type         job
);
   import tsp_pkg::*;

   localparam logic [LEN_W+1:0] MaxLen = (LEN_W+2)'(MAX_PES_BYTES);

   logic [LEN_W-1:0] consumed_ff, consumed_in;
   logic [LEN_W-1:0] latched_ff, latched_in;
   logic [7:0]       left_ff, left_in;
   logic [3:0]       cc_ff, cc_in;

   logic             first;
   logic             new_pkt;
   logic [LEN_W-1:0] len_fix;
   logic [LEN_W-1:0] len_clamped;
   logic [LEN_W-1:0] remaining;
   logic [LEN_W-1:0] consumed_inc;
   logic [7:0]       left_eff;
   logic [7:0]       pay;
   logic             finished;

   always_comb begin
      first = (consumed_ff == '0);
      len_fix = (req.pes_length == '0) ? LEN_W'(1) : req.pes_length;
      len_clamped = ({2'b00, len_fix} > MaxLen) ? MaxLen[LEN_W-1:0] : len_fix;
      latched_in = first ? len_clamped : latched_ff;
      left_eff = first ? 8'd0 : left_ff;
      new_pkt = (left_eff == 8'd0);
      remaining = latched_in - consumed_ff;

      if (first) begin
         pay = (remaining < LEN_W'(FIRST_PAY_MAX)) ? remaining[7:0] : FIRST_PAY_MAX;
      end else begin
         pay = (remaining < LEN_W'(PAY_MAX)) ? remaining[7:0] : PAY_MAX;
         // A single leftover byte cannot be stuffed, so 183 drops to 182.
         if (pay == PAY_AWKWARD) begin
            pay = PAY_CUT;
         end
      end

      consumed_inc = consumed_ff + LEN_W'(1);
      finished = (consumed_inc >= latched_in);
      left_in = (new_pkt ? pay : left_eff) - 8'd1;
      consumed_in = consumed_inc;
      if (finished) begin
         consumed_in = '0;
         left_in = 8'd0;
      end
      cc_in = new_pkt ? cc_ff + 4'd1 : cc_ff;

      job.data_byte = req.data_byte;
      job.pcr = req.clock_reference;
      job.pay = pay;
      job.cc = cc_ff;
      job.first = first;
      job.hdr = new_pkt;
      job.finished = finished;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         consumed_ff <= '0;
         latched_ff <= '0;
         left_ff <= '0;
         cc_ff <= '0;
      end else if (accept) begin
         consumed_ff <= consumed_in;
         latched_ff <= latched_in;
         left_ff <= left_in;
         cc_ff <= cc_in;
      end
   end

endmodule

// ===== rtl/tsp_queue.sv =====
// Short job queue between the front end and the emitter.
// Depends on tsp_pkg.
module tsp_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  tsp_pkg::job_type          push_job,
   input  logic                      pop,
   output tsp_pkg::job_type          head_job,
   output tsp_pkg::queue_status_type status
);
   import tsp_pkg::*;

   job_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   always_comb begin
      status.full = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      status.empty = (count_ff == '0);
      head_job = entry_ff[rd_ptr_ff];
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in = count_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/tsp_back.sv =====
// Emitter: walks the header, adaptation field, stuffing and payload slots
// of the head job, one result per cycle unless stalled, into the output register.
// Depends on tsp_pkg.
module tsp_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [tsp_pkg::PID_W-1:0]       pid,
   input  tsp_pkg::job_type                head_job,
   input  logic                            head_valid,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tsp_pkg::rsp_payload_type        rsp_payload
);
   import tsp_pkg::*;

   slot_type        slot_ff, slot_in;
   logic            active_ff, active_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   slot_type cur_slot;
   logic     emit;
   logic     adapt;
   logic     has_stuff;
   logic [7:0] alen;
   logic [7:0] stuff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_SYNC;
         active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         active_ff <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_comb begin
      adapt = head_job.first || (head_job.pay < PAY_MAX);
      alen = ADAPT_SPAN - head_job.pay;
      stuff = head_job.first ? FIRST_PAY_MAX - head_job.pay : PAY_CUT - head_job.pay;
      has_stuff = (stuff != 8'd0);

      if (active_ff) begin
         cur_slot = slot_ff;
      end else begin
         cur_slot = head_job.hdr ? SLOT_SYNC : SLOT_DATA;
      end

      emit = head_valid && (!rsp_valid_ff || rsp_ready);
      pop = emit && (cur_slot == SLOT_DATA);

      rsp_in = rsp_ff;
      rsp_in.repeat_count = ONE_BEAT;
      rsp_in.packet_begin = 1'b0;
      rsp_in.pes_finished = 1'b0;
      rsp_in.last_of_run = 1'b0;
      slot_in = slot_type'(cur_slot + 4'd1);

      case (cur_slot)
         SLOT_SYNC: begin
            rsp_in.ts_byte = SYNC_BYTE;
            rsp_in.packet_begin = 1'b1;
         end
         SLOT_PID_HI: begin
            rsp_in.ts_byte = (head_job.first ? PUSI_BIT : ZERO_BYTE) | {3'b000, pid[12:8]};
         end
         SLOT_PID_LO: begin
            rsp_in.ts_byte = pid[7:0];
         end
         SLOT_CC: begin
            rsp_in.ts_byte = {adapt ? AFC_ADAPT : AFC_PAYLOAD, head_job.cc};
            slot_in = adapt ? SLOT_ALEN : SLOT_DATA;
         end
         SLOT_ALEN: begin
            rsp_in.ts_byte = alen;
         end
         SLOT_FLAGS: begin
            rsp_in.ts_byte = head_job.first ? PCR_FLAG : ZERO_BYTE;
            if (!head_job.first) begin
               slot_in = has_stuff ? SLOT_STUFF : SLOT_DATA;
            end
         end
         SLOT_PCR0: begin
            rsp_in.ts_byte = head_job.pcr[32:25];
         end
         SLOT_PCR1: begin
            rsp_in.ts_byte = head_job.pcr[24:17];
         end
         SLOT_PCR2: begin
            rsp_in.ts_byte = head_job.pcr[16:9];
         end
         SLOT_PCR3: begin
            rsp_in.ts_byte = head_job.pcr[8:1];
         end
         SLOT_PCR4: begin
            rsp_in.ts_byte = {head_job.pcr[0], PCR_RESERVED};
         end
         SLOT_PCR5: begin
            rsp_in.ts_byte = ZERO_BYTE;
            slot_in = has_stuff ? SLOT_STUFF : SLOT_DATA;
         end
         SLOT_STUFF: begin
            // The whole stuffing run leaves as one beat with its length.
            rsp_in.ts_byte = STUFF_BYTE;
            rsp_in.repeat_count = stuff;
         end
         SLOT_DATA: begin
            rsp_in.ts_byte = head_job.data_byte;
            rsp_in.pes_finished = head_job.finished;
            rsp_in.last_of_run = 1'b1;
            slot_in = SLOT_SYNC;
         end
         default: begin
            rsp_in.ts_byte = ZERO_BYTE;
            slot_in = SLOT_SYNC;
         end
      endcase

      if (!emit) begin
         rsp_in = rsp_ff;
         slot_in = slot_ff;
         active_in = active_ff;
      end else begin
         active_in = (cur_slot != SLOT_DATA);
      end

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rsp_valid = rsp_valid_ff;
      rsp_payload = rsp_ff;
   end

endmodule

// ===== rtl/ts_packetizer_with_pcr_core.sv =====
// Top level of the transport stream packetizer with PCR insertion.
// Depends on tsp_pkg, tsp_front, tsp_queue and tsp_back.
//
//   channel | ports                             | direction | beat
//   req     | req_valid/req_ready/req_payload   | in        | one PES byte
//   rsp     | rsp_valid/rsp_ready/rsp_payload   | out       | one result
//   csr     | csr_valid/csr_ready/csr_data      | in        | PID write
//
// A byte inside a packet yields one result; a byte that opens a packet yields
// 5 to 14 results, one per cycle while the output is not stalled. The emitter's
// one result per cycle sets the rate; a four-job queue lets the input keep
// accepting while headers drain. A result passes through the job queue and the
// output register after its byte is accepted. Reset is synchronous and clears
// all control state; the PID returns to 256. Either side may stall at any time.
module ts_packetizer_with_pcr_core #(
   parameter int MAX_PES_BYTES = 4194304
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  tsp_pkg::req_payload_type        req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output tsp_pkg::rsp_payload_type        rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tsp_pkg::PID_W-1:0]       csr_data
);
   import tsp_pkg::*;

   logic [PID_W-1:0] pid_ff;
   logic             req_accept;
   job_type          front_job;
   job_type          head_job;
   queue_status_type q_status;
   logic             pop;

   assign csr_ready = 1'b1;
   assign req_ready = !q_status.full;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_ff <= PID_RESET;
      end else if (csr_valid && csr_ready) begin
         pid_ff <= csr_data;
      end
   end

   tsp_front #(
      .MAX_PES_BYTES(MAX_PES_BYTES)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .accept(req_accept),
      .req   (req_payload),
      .job   (front_job)
   );

   tsp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_accept),
      .push_job(front_job),
      .pop     (pop),
      .head_job(head_job),
      .status  (q_status)
   );

   tsp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pid        (pid_ff),
      .head_job   (head_job),
      .head_valid (!q_status.empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

`ifndef ASSERT_OFF
   a_stuff_only_repeats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.repeat_count != ONE_BEAT) |->
         rsp_payload.ts_byte == STUFF_BYTE)
      else $error("repeat count above one on a byte that is not stuffing");

   a_finish_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.pes_finished |-> rsp_payload.last_of_run)
      else $error("PES end flagged on a beat that does not close its run");

   a_sync_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.packet_begin |->
         !rsp_payload.last_of_run && rsp_payload.ts_byte == SYNC_BYTE)
      else $error("sync beat malformed or closing a run");

   a_pop_needs_job: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("emitter retired a job from an empty queue");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ts_packetizer_with_pcr_core. PES bytes are sent over the request
// channel and every transport stream result is checked against a predicted byte sequence.
// Depends on tsp_pkg and the packetizer RTL.
module tb;
   import tsp_pkg::*;

   localparam int PES_CAP = 4194304;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BYTES = 30;

   class ts_scoreboard;
      logic [PID_W-1:0] pid;
      logic [LEN_W-1:0] offset;
      logic [LEN_W-1:0] pes_len;
      logic [7:0]       left;
      logic [3:0]       cc;
      rsp_payload_type  due[$];
      int               failures;

      function new();
         pid = PID_RESET;
         offset = '0;
         pes_len = '0;
         left = '0;
         cc = '0;
         failures = 0;
      endfunction

      function void add_result(logic [7:0] value, logic [7:0] count, logic sync);
         rsp_payload_type r;
         r.ts_byte = value;
         r.repeat_count = count;
         r.packet_begin = sync;
         r.pes_finished = 1'b0;
         r.last_of_run = 1'b0;
         due.insert(due.size(), r);
      endfunction

      // Works out every result that one accepted PES byte causes.
      function void note_byte(req_payload_type p);
         logic [LEN_W-1:0] len;
         logic [LEN_W-1:0] remaining;
         logic [7:0]       pay;
         logic [7:0]       alen;
         logic [7:0]       stuff;
         logic             first_pkt;
         logic             adapt;
         rsp_payload_type  r;
         if (offset == '0) begin
            len = p.pes_length;
            if (len == '0) len = LEN_W'(1);
            if (len > LEN_W'(PES_CAP)) len = LEN_W'(PES_CAP);
            pes_len = len;
            left = '0;
         end
         if (left == '0) begin
            first_pkt = (offset == '0);
            remaining = pes_len - offset;
            if (first_pkt) begin
               pay = (remaining < FIRST_PAY_MAX) ? remaining[7:0] : FIRST_PAY_MAX;
            end else begin
               pay = (remaining < PAY_MAX) ? remaining[7:0] : PAY_MAX;
               if (pay == PAY_AWKWARD) pay = PAY_CUT;
            end
            adapt = first_pkt || (pay < PAY_MAX);
            add_result(SYNC_BYTE, ONE_BEAT, 1'b1);
            add_result((first_pkt ? PUSI_BIT : ZERO_BYTE) | {3'b000, pid[12:8]}, ONE_BEAT, 1'b0);
            add_result(pid[7:0], ONE_BEAT, 1'b0);
            add_result({adapt ? AFC_ADAPT : AFC_PAYLOAD, cc}, ONE_BEAT, 1'b0);
            cc = cc + 4'd1;
            if (adapt) begin
               alen = ADAPT_SPAN - pay;
               stuff = alen - 8'd1;
               add_result(alen, ONE_BEAT, 1'b0);
               add_result(first_pkt ? PCR_FLAG : ZERO_BYTE, ONE_BEAT, 1'b0);
               if (first_pkt) begin
                  add_result(p.clock_reference[32:25], ONE_BEAT, 1'b0);
                  add_result(p.clock_reference[24:17], ONE_BEAT, 1'b0);
                  add_result(p.clock_reference[16:9], ONE_BEAT, 1'b0);
                  add_result(p.clock_reference[8:1], ONE_BEAT, 1'b0);
                  add_result({p.clock_reference[0], PCR_RESERVED}, ONE_BEAT, 1'b0);
                  add_result(ZERO_BYTE, ONE_BEAT, 1'b0);
                  stuff = stuff - 8'd6;
               end
               // A full packet leaves no room for stuffing, so no run is emitted.
               if (stuff != '0) add_result(STUFF_BYTE, stuff, 1'b0);
            end
            left = pay;
         end
         left = left - 8'd1;
         offset = offset + LEN_W'(1);
         r.ts_byte = p.data_byte;
         r.repeat_count = ONE_BEAT;
         r.packet_begin = 1'b0;
         r.pes_finished = (offset >= pes_len);
         r.last_of_run = 1'b1;
         if (r.pes_finished) begin
            offset = '0;
            left = '0;
         end
         due.insert(due.size(), r);
      endfunction

      function void compare_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_payload_type got);
         rsp_payload_type want;
         if (due.size() == 0) begin
            $error("result ts_byte 0x%0h arrived with nothing outstanding", got.ts_byte);
            failures++;
            return;
         end
         want = due[0];
         due.delete(0);
         compare_field("ts_byte", want.ts_byte, got.ts_byte);
         compare_field("repeat_count", want.repeat_count, got.repeat_count);
         compare_field("packet_begin", want.packet_begin, got.packet_begin);
         compare_field("pes_finished", want.pes_finished, got.pes_finished);
         compare_field("last_of_run", want.last_of_run, got.last_of_run);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   req_payload_type  req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   rsp_payload_type  rsp_payload;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [PID_W-1:0] csr_data = '0;

   logic             steady = 1'b0;
   int               cycles = 0;
   ts_scoreboard     sb = new();

   ts_packetizer_with_pcr_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Result side: check each accepted beat and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_payload);
      rsp_ready <= steady || ($urandom_range(0, 99) >= 23);
   end

   function automatic req_payload_type pes_beat(logic [7:0] data, logic [LEN_W-1:0] len,
                                                logic [PCR_W-1:0] pcr);
      req_payload_type p;
      p.data_byte = data;
      p.pes_length = len;
      p.clock_reference = pcr;
      return p;
   endfunction

   // Valid is left high on return; the caller either offers the next beat or drops it.
   task automatic send_byte(input req_payload_type p);
      if (!steady && $urandom_range(0, 99) < 23) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!steady && $urandom_range(0, 99) < 23);
      end
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(p);
   endtask

   task automatic hold_off();
      req_valid <= 1'b0;
      while (sb.due.size() != 0) @(posedge clock);
   endtask

   task automatic write_pid(input logic [PID_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.pid = value;
      csr_valid <= 1'b0;
   endtask

   // Only the first byte's length matters; later bytes carry random, ignored lengths.
   task automatic run_pes(input logic [LEN_W-1:0] len_field, input int count);
      req_payload_type p;
      for (int i = 0; i < count; i++) begin
         p.data_byte = 8'($urandom);
         p.pes_length = (i == 0) ? len_field : LEN_W'($urandom);
         p.clock_reference = {1'($urandom), 32'($urandom)};
         send_byte(p);
      end
   endtask

   initial begin
      int               sent;
      int               pick;
      int               count;
      logic [LEN_W-1:0] len;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset PID first: zero length, single bytes and short PESes with extreme fields.
      send_byte(pes_beat(8'h00, '0, '0));
      send_byte(pes_beat(8'hff, 23'd1, 33'h1_ffff_ffff));
      send_byte(pes_beat(8'h5a, 23'd2, 33'h0_aaaa_aaab));
      send_byte(pes_beat(8'ha5, 23'h7f_ffff, 33'h1_5555_5554));
      send_byte(pes_beat(8'h01, 23'd3, 33'h1_0000_0000));
      send_byte(pes_beat(8'h80, '0, 33'h0_ffff_ffff));
      send_byte(pes_beat(8'h7f, 23'h40_0000, '0));
      hold_off();
      write_pid(13'h1fff);
      send_byte(pes_beat(8'hc3, 23'd1, 33'h0_0000_0001));
      send_byte(pes_beat(8'h3c, 23'd2, 33'h1_8000_0000));
      send_byte(pes_beat(8'h99, 23'd5, 33'h0_7fff_fffe));
      hold_off();
      write_pid('0);
      send_byte(pes_beat(8'h42, 23'd1, 33'h0_1234_5679));
      hold_off();
      write_pid(PID_W'($urandom));

      // Mostly short PESes, so that packet headers and the continuity wrap come often.
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         pick = $urandom_range(0, 99);
         if (pick < 85) len = LEN_W'($urandom_range(0, 3));
         else len = LEN_W'($urandom_range(13, 20));
         count = (len == '0) ? 1 : int'(len);
         run_pes(len, count);
         sent += count;
         if ($urandom_range(0, 9) == 0) hold_off();
      end

      // A remainder of 183 after the full first packet is cut to 182. The middle of this PES
      // runs with no idling on either side.
      hold_off();
      write_pid(13'h0aaa);
      run_pes(23'd359, 50);
      steady = 1'b1;
      run_pes(23'd359, 90);
      steady = 1'b0;
      run_pes(23'd359, 37);

      hold_off();
      repeat (20) @(posedge clock);
      if (sb.failures == 0 && sb.due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
